### rtl/core/tpba_pkg.sv
// tpba_pkg: shared types and constants for the two-pool bitmap page allocator
// used by tpba_pool and two_pool_bitmap_page_allocator; no dependencies
package tpba_pkg;

  localparam int unsigned ADDR_W        = 52;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned SMALL_CNT_W   = 7;
  localparam int unsigned LARGE_CNT_W   = 3;
  localparam int unsigned SMALL_SHIFT   = 21;
  localparam int unsigned LARGE_SHIFT   = 30;

  localparam logic [ADDR_W-1:0] SMALL_BASE_RST = ADDR_W'(64'h0000_0000_3000_0000);
  localparam logic [ADDR_W-1:0] LARGE_BASE_RST = ADDR_W'(64'h0000_0001_0000_0000);

  localparam logic [CFG_IDX_W-1:0] CFG_GIG_EN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE = 2'd2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    ORDER_SMALL = 1'b0,
    ORDER_LARGE = 1'b1
  } order_e;

  typedef struct packed {
    op_e               opcode;
    order_e            page_order;
    logic [ADDR_W-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      page_address;
    logic                   done_ok;
    logic [SMALL_CNT_W-1:0] small_free_count;
    logic [LARGE_CNT_W-1:0] large_free_count;
  } rsp_t;

  typedef struct packed {
    logic alloc;
    logic release_pg;
  } pool_ctl_t;

endpackage

### rtl/core/tpba_pool.sv
// tpba_pool: one page pool with used-bit map, free count, first-free search
// and address-to-slot mapping; depends on tpba_pkg
module tpba_pool import tpba_pkg::*; #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned SHIFT = 21,
  localparam int unsigned CW   = $clog2(SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pool_ctl_t         ctl_i,
  input  logic [ADDR_W-1:0] base_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic              ok_o,
  output logic [ADDR_W-1:0] page_o,
  output logic [CW-1:0]     count_o
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned HIW  = ADDR_W - SHIFT;

  logic [SLOTS-1:0]  used_q, used_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              found;
  logic [IDXW-1:0]   free_idx;
  logic [HIW-1:0]    diff_hi;
  logic              in_range;
  logic [IDXW-1:0]   rel_idx;
  logic              rel_hit;

  // lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        found    = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  assign diff_hi  = HIW'((addr_i - base_i) >> SHIFT);
  assign in_range = (addr_i >= base_i) && (diff_hi < HIW'(SLOTS));
  assign rel_idx  = diff_hi[IDXW-1:0];
  assign rel_hit  = in_range && used_q[rel_idx];

  always_comb begin
    used_d = used_q;
    cnt_d  = cnt_q;
    ok_o   = 1'b0;
    page_o = '0;
    if (ctl_i.alloc && found) begin
      used_d[free_idx] = 1'b1;
      cnt_d            = cnt_q - CW'(1);
      ok_o             = 1'b1;
      page_o           = base_i + (ADDR_W'(free_idx) << SHIFT);
    end else if (ctl_i.release_pg && rel_hit) begin
      used_d[rel_idx] = 1'b0;
      cnt_d           = cnt_q + CW'(1);
      ok_o            = 1'b1;
    end
  end

  assign count_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      cnt_q  <= CW'(SLOTS);
    end else begin
      used_q <= used_d;
      cnt_q  <= cnt_d;
    end
  end

  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'($countones(used_q)) + int'(cnt_q) == int'(SLOTS))
    else $error("free count out of step with used map");

  a_alloc_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.alloc && ok_o) |=> used_q[$past(free_idx)])
    else $error("allocated slot not marked used");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.alloc && ctl_i.release_pg))
    else $error("alloc and free requested together");

endmodule

### rtl/core/two_pool_bitmap_page_allocator.sv
// two_pool_bitmap_page_allocator: top level with config registers, request and
// result registers and two tpba_pool instances; depends on tpba_pkg, tpba_pool
//
// A request is taken on every cycle that start is high; busy is always low.
// Each request gives one result on rsp_o, marked by done_o, after it has passed
// through the request register and then the result register.
// The whole search and map update sits between those two registers, so a
// request sees every earlier request's effect and one request per cycle is
// sustained. done_o is a one-cycle strobe and cannot be held off.
module two_pool_bitmap_page_allocator import tpba_pkg::*; #(
  parameter int unsigned SMALL_POOL_SLOTS = 64,
  parameter int unsigned LARGE_POOL_SLOTS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int unsigned SCW = $clog2(SMALL_POOL_SLOTS + 1);
  localparam int unsigned LCW = $clog2(LARGE_POOL_SLOTS + 1);

  logic              gig_en_q;
  logic [ADDR_W-1:0] small_base_q, large_base_q;
  req_t              req_q;
  logic              req_vld_q;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_vld_q;
  pool_ctl_t         s_ctl, l_ctl;
  logic              s_ok, l_ok;
  logic [ADDR_W-1:0] s_page, l_page;
  logic [SCW-1:0]    s_cnt;
  logic [LCW-1:0]    l_cnt;

  assign busy = 1'b0;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gig_en_q     <= 1'b0;
      small_base_q <= SMALL_BASE_RST;
      large_base_q <= LARGE_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GIG_EN:     gig_en_q     <= cfg_data_i[0];
        CFG_SMALL_BASE: small_base_q <= cfg_data_i;
        CFG_LARGE_BASE: large_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    s_ctl.alloc      = req_vld_q && (req_q.page_order == ORDER_SMALL)
                       && (req_q.opcode == OP_ALLOC);
    s_ctl.release_pg = req_vld_q && (req_q.page_order == ORDER_SMALL)
                       && (req_q.opcode == OP_FREE);
    l_ctl.alloc      = req_vld_q && gig_en_q && (req_q.page_order == ORDER_LARGE)
                       && (req_q.opcode == OP_ALLOC);
    l_ctl.release_pg = req_vld_q && gig_en_q && (req_q.page_order == ORDER_LARGE)
                       && (req_q.opcode == OP_FREE);
  end

  tpba_pool #(
    .SLOTS (SMALL_POOL_SLOTS),
    .SHIFT (SMALL_SHIFT)
  ) u_small (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s_ctl),
    .base_i  (small_base_q),
    .addr_i  (req_q.release_address),
    .ok_o    (s_ok),
    .page_o  (s_page),
    .count_o (s_cnt)
  );

  tpba_pool #(
    .SLOTS (LARGE_POOL_SLOTS),
    .SHIFT (LARGE_SHIFT)
  ) u_large (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (l_ctl),
    .base_i  (large_base_q),
    .addr_i  (req_q.release_address),
    .ok_o    (l_ok),
    .page_o  (l_page),
    .count_o (l_cnt)
  );

  always_comb begin
    rsp_d.page_address     = (req_q.page_order == ORDER_LARGE) ? l_page : s_page;
    rsp_d.done_ok          = s_ok || l_ok;
    rsp_d.small_free_count = SMALL_CNT_W'(s_cnt);
    rsp_d.large_free_count = gig_en_q ? LARGE_CNT_W'(l_cnt) : '0;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = rsp_vld_q;
  assign rsp_o  = rsp_q;

  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_vld_q))
    else $error("result without request");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.done_ok) |-> (rsp_o.page_address == '0))
    else $error("failed request returned an address");

  a_large_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !gig_en_q) |-> (rsp_o.large_free_count == '0))
    else $error("large count shown while pool disabled");

  a_single_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ok && l_ok))
    else $error("both pools acted on one request");

endmodule
